/* rtl/pltc_pkg.sv */
// Package for the path length and turn count unit: widths, defaults, sequencer states.
// No dependencies.
`default_nettype none
package pltc_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COS_BITS       = 16;
    localparam int COS_FRAC       = 14;
    localparam int LEN_W          = 48;
    localparam int TURN_W         = 32;
    localparam logic signed [COS_BITS-1:0] COS_RESET = 16'sd14189;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT,
        ST_ACC,
        ST_DOT_X,
        ST_DOT_Y,
        ST_LEN_AB,
        ST_LEN_CL,
        ST_LEN_CH,
        ST_CMP,
        ST_OUT
    } pltc_state_t;
endpackage
`default_nettype wire

/* rtl/path_length_and_turn_count_unit.sv */
// Path length and turn count unit: top level, one shared multiplier under a sequencer.
// Depends on pltc_pkg.
//
// Usage: points enter on s_axis (tdata = {y_coord, x_coord}, tlast = last point of the
// path). Each point is processed by a sequencer that reuses one RW x RW multiplier and
// one bit-serial square root (one result bit a cycle), RW = COORD_BITS + 2 (34).
// A point on which a corner is tested takes longer than one without; the first point of
// a path goes straight to the output step. s_axis_tready is low while a point is at
// work, so a new point is taken only once the last one is through.
// After the point flagged by tlast one transfer appears on m_axis, m_axis_tvalid rising
// at the same edge as s_axis_tready returns: tdata holds total_length (bits 47:0) and
// turn_total (bits 79:48). The result waits in an output register while m_axis_tready
// is low; further points are still taken, and the sequencer holds in its last step only
// when another result is ready and the register is still full. The path state then
// clears; cos_threshold stays. Reset (rst_n low) clears the path state and loads
// cos_threshold with 14189. cfg_we/cfg_data write cos_threshold (Q1.14); the user
// must do so only while the block is idle, which the block itself does not enforce.
`default_nettype none
module path_length_and_turn_count_unit
    import pltc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // x_coord[31:0], y_coord[63:32]
    input  wire logic         s_axis_tlast,   // last_point
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [79:0]       m_axis_tdata    // total_length[47:0], turn_total[79:48]
);
    localparam int DW  = COORD_BITS + 1;          // delta width
    localparam int MW  = DW;                      // magnitude width
    localparam int SQW = 2 * MW + 1;              // sum of squares
    localparam int RW  = MW + 1;                  // root width
    localparam int PW  = 2 * MW;                  // product width
    localparam int MUW = (RW > COS_BITS + 1) ? RW : COS_BITS + 1;
    localparam int LHW = 2 * MW + 1 + COS_FRAC;   // dot << 14
    localparam int RHW = 2 * RW + COS_BITS;       // la*lb*|c|
    localparam int CW  = (LHW > RHW) ? LHW : RHW;
    localparam int CNW = $clog2(RW + 1);
    localparam int SUMW = ((LEN_W > RW) ? LEN_W : RW) + 1;
    localparam logic [RW+20:0] UNIT = (RW+21)'(1) << FRAC_BITS;

    pltc_state_t state_reg, state_next;

    logic signed [COS_BITS-1:0] cos_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, cx_reg, cy_reg;
    logic signed [DW-1:0] pdx_reg, pdy_reg, dx_reg, dy_reg;
    logic [RW-1:0] plen_reg, root_reg;
    logic [1:0] seen_reg;
    logic last_reg;
    logic [LEN_W-1:0] lsum_reg;
    logic [TURN_W-1:0] tsum_reg;
    logic [SQW-1:0] sq_reg;
    logic [SQW+1:0] rem_reg;
    logic [CNW-1:0] cnt_reg;
    logic [PW-1:0] p1_reg;
    logic [CW-1:0] lhs_reg, rhs_reg;
    logic sl_reg;
    logic [2*RW-1:0] ab_reg;
    logic [79:0] out_reg;
    logic ovalid_reg;
    logic did_seg;
    logic out_stall, out_load;

    // shared multiplier
    logic [MUW-1:0] ma, mb;
    logic [2*MUW-1:0] mp;
    assign mp = ma * mb;

    function automatic logic [MW-1:0] magf(input logic signed [DW-1:0] d);
        magf = d[DW-1] ? MW'(-d) : MW'(d);
    endfunction

    logic signed [COORD_BITS-1:0] xin, yin;
    assign xin = COORD_BITS'(s_axis_tdata[31:0]);
    assign yin = COORD_BITS'(s_axis_tdata[63:32]);

    logic [COS_BITS:0] cmag;
    assign cmag = cos_reg[COS_BITS-1] ? (COS_BITS+1)'(-(COS_BITS+1)'(cos_reg)) :
                                        (COS_BITS+1)'(cos_reg);

    // a finished result cannot be placed while the output register is still full
    assign out_stall = (state_reg == ST_OUT) && last_reg && ovalid_reg && !m_axis_tready;
    assign out_load  = (state_reg == ST_OUT) && last_reg && !out_stall;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    // sqrt step (restoring, two bits of radicand a cycle)
    logic [SQW+1:0] trial, rem_sh;
    logic [RW+1:0] tq;
    logic [CNW:0] sh;
    always_comb
    begin
        sh     = (CNW+1)'(2) * (CNW+1)'(cnt_reg);
        rem_sh = {rem_reg[SQW-1:0], 2'b00} | (SQW+2)'((sq_reg >> sh) & 2'b11);
        tq     = {root_reg, 2'b01};
        trial  = rem_sh - (SQW+2)'(tq);
    end

    logic short_a, short_b;
    assign short_a = ((RW+21)'(plen_reg) * (RW+21)'(1000000)) < UNIT;
    assign short_b = ((RW+21)'(root_reg) * (RW+21)'(1000000)) < UNIT;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            ST_SQ_X:   begin ma = MUW'(magf(dx_reg)); mb = ma; end
            ST_SQ_Y:   begin ma = MUW'(magf(dy_reg)); mb = ma; end
            ST_DOT_X:  begin ma = MUW'(magf(pdx_reg)); mb = MUW'(magf(dx_reg)); end
            ST_DOT_Y:  begin ma = MUW'(magf(pdy_reg)); mb = MUW'(magf(dy_reg)); end
            ST_LEN_AB: begin ma = MUW'(plen_reg); mb = MUW'(root_reg); end
            ST_LEN_CL: begin ma = MUW'(ab_reg[RW-1:0]); mb = MUW'(cmag); end
            ST_LEN_CH: begin ma = MUW'(ab_reg[2*RW-1:RW]); mb = MUW'(cmag); end
            default:   begin ma = '0; mb = '0; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_axis_tvalid && s_axis_tready)
                           state_next = (seen_reg == 2'd0) ? ST_OUT : ST_SQ_X;
            ST_SQ_X:   state_next = ST_SQ_Y;
            ST_SQ_Y:   state_next = ST_ROOT;
            ST_ROOT:   if (cnt_reg == '0) state_next = ST_ACC;
            ST_ACC:    state_next = (seen_reg == 2'd2 && !short_a && !short_b) ?
                                    ST_DOT_X : ST_OUT;
            ST_DOT_X:  state_next = ST_DOT_Y;
            ST_DOT_Y:  state_next = ST_LEN_AB;
            ST_LEN_AB: state_next = ST_LEN_CL;
            ST_LEN_CL: state_next = ST_LEN_CH;
            ST_LEN_CH: state_next = ST_CMP;
            ST_CMP:    state_next = ST_OUT;
            ST_OUT:    state_next = out_stall ? ST_OUT : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // dot combine done in ST_DOT_Y
    logic s1, s2, sr, lz, rz, turn;
    logic [PW:0] dotm;
    logic [PW:0] p2;
    logic dsl;
    always_comb
    begin
        s1 = pdx_reg[DW-1] ^ dx_reg[DW-1];
        s2 = pdy_reg[DW-1] ^ dy_reg[DW-1];
        p2 = (PW+1)'(mp[PW-1:0]);
        if (s1 == s2)
        begin
            dotm = (PW+1)'(p1_reg) + p2;
            dsl  = s1;
        end
        else if ((PW+1)'(p1_reg) >= p2)
        begin
            dotm = (PW+1)'(p1_reg) - p2;
            dsl  = s1;
        end
        else
        begin
            dotm = p2 - (PW+1)'(p1_reg);
            dsl  = s2;
        end
        lz = (lhs_reg == '0);
        rz = (rhs_reg == '0);
        sr = cos_reg[COS_BITS-1] && !rz;
        if ((sl_reg && !lz) != sr) turn = sl_reg && !lz;
        else if (!(sl_reg && !lz)) turn = lhs_reg < rhs_reg;
        else turn = lhs_reg > rhs_reg;
    end

    logic [SUMW-1:0] lsum_add;
    assign lsum_add = SUMW'(lsum_reg) + SUMW'(root_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cos_reg    <= COS_RESET;
            seen_reg   <= 2'd0;
            lsum_reg   <= '0;
            tsum_reg   <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            pdx_reg    <= '0;
            pdy_reg    <= '0;
            plen_reg   <= '0;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) cos_reg <= cfg_data;
            if (out_load) ovalid_reg <= 1'b1;
            else if (m_axis_tready) ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        cx_reg   <= xin;
                        cy_reg   <= yin;
                        last_reg <= s_axis_tlast;
                        dx_reg   <= DW'(xin) - DW'(px_reg);
                        dy_reg   <= DW'(yin) - DW'(py_reg);
                        if (seen_reg == 2'd0) seen_reg <= 2'd1;
                    end
                ST_SQ_X: sq_reg <= SQW'(mp[PW-1:0]);
                ST_SQ_Y:
                begin
                    sq_reg   <= sq_reg + SQW'(mp[PW-1:0]);
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= CNW'(RW - 1);
                end
                ST_ROOT:
                begin
                    if (!trial[SQW+1])
                    begin
                        rem_reg  <= trial;
                        root_reg <= {root_reg[RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[RW-2:0], 1'b0};
                    end
                    if (cnt_reg != '0) cnt_reg <= cnt_reg - 1'b1;
                end
                ST_ACC:
                    lsum_reg <= (lsum_add[SUMW-1:LEN_W] != '0) ? '1 : lsum_add[LEN_W-1:0];
                ST_DOT_X: p1_reg <= mp[PW-1:0];
                ST_DOT_Y:
                begin
                    lhs_reg <= CW'(dotm) << COS_FRAC;
                    sl_reg  <= dsl;
                end
                ST_LEN_AB: ab_reg <= mp[2*RW-1:0];
                ST_LEN_CL: rhs_reg <= CW'(mp);
                ST_LEN_CH: rhs_reg <= rhs_reg + (CW'(mp) << RW);
                ST_CMP:
                    if (turn && tsum_reg != '1) tsum_reg <= tsum_reg + 1'b1;
                ST_OUT:
                    if (!out_stall)
                    begin
                        if (last_reg)
                        begin
                            out_reg  <= {tsum_reg, lsum_reg};
                            seen_reg <= 2'd0;
                            lsum_reg <= '0;
                            tsum_reg <= '0;
                            px_reg   <= '0;
                            py_reg   <= '0;
                            pdx_reg  <= '0;
                            pdy_reg  <= '0;
                            plen_reg <= '0;
                        end
                        else
                        begin
                            px_reg <= cx_reg;
                            py_reg <= cy_reg;
                            if (did_seg)
                            begin
                                pdx_reg  <= dx_reg;
                                pdy_reg  <= dy_reg;
                                plen_reg <= root_reg;
                                seen_reg <= 2'd2;
                            end
                        end
                    end
                default: ;
            endcase
        end
    end

    // a segment was computed for this point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            did_seg <= 1'b0;
        else if (state_reg == ST_IDLE)
            did_seg <= 1'b0;
        else if (state_reg == ST_ACC)
            did_seg <= 1'b1;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("held result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT && cnt_reg == '0) |=> (state_reg == ST_ACC))
        else $error("root did not finish");
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg != 2'd3)
        else $error("bad point count");
endmodule
`default_nettype wire

/* verif/testbench.sv */
// Testbench for path_length_and_turn_count_unit: paths of Q16.16 points are streamed in,
// and each path's length and turn count is checked against a cycle-free predictor.
// Depends on pltc_pkg and the unit's RTL.
`timescale 1ns / 1ps
module testbench
    import pltc_pkg::*;
();

    typedef struct packed {
        logic [TURN_W-1:0] turns;
        logic [LEN_W-1:0]  length;
    } path_result_t;

    localparam logic [31:0] UNIT = 32'h0001_0000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;

    path_length_and_turn_count_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    logic signed [15:0] cos_thr;
    logic [31:0]        last_x, last_y;
    logic signed [32:0] last_dx, last_dy;
    logic [33:0]        last_len;
    int                 pts_in_path;
    logic [LEN_W-1:0]   len_acc;
    logic [TURN_W-1:0]  turn_acc;

    path_result_t expected_paths[$];
    int  err_count;
    int  points_sent;
    int  paths_checked;
    int  burst_left;
    bit  sender_gaps;
    int  hold_cycles;
    int  stretch_left;
    int  ready_mode;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [33:0] root_floor(input logic [66:0] v);
        logic [33:0] r;
        logic [33:0] t;
        logic [67:0] sq;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            t  = r | (34'd1 << b);
            sq = {34'd0, t} * {34'd0, t};
            if (sq <= {1'b0, v})
                r = t;
        end
        return r;
    endfunction

    function automatic bit is_short(input logic [33:0] len);
        return (64'(len) * 64'd1000000) < 64'(UNIT);
    endfunction

    function automatic bit corner_is_turn(input logic signed [32:0] ax, ay, bx, by,
                                          input logic [33:0] la, lb,
                                          input logic signed [15:0] c);
        logic signed [99:0] dotp;
        logic signed [99:0] rhs;
        dotp = 100'(ax) * 100'(bx) + 100'(ay) * 100'(by);
        rhs  = 100'(c) * $signed({66'd0, la}) * $signed({66'd0, lb});
        return (dotp * 100'sd16384) < rhs;
    endfunction

    task automatic clear_path_state();
        last_x = '0; last_y = '0; last_dx = '0; last_dy = '0;
        last_len = '0; pts_in_path = 0; len_acc = '0; turn_acc = '0;
    endtask

    task automatic predict_point(input logic [31:0] x, y, input bit last);
        logic signed [32:0] dx, dy;
        logic signed [67:0] wx, wy;
        logic [33:0]        len;
        logic [LEN_W:0]     sum;
        path_result_t       res;
        if (pts_in_path == 0)
            pts_in_path = 1;
        else
        begin
            dx  = {x[31], x} - {last_x[31], last_x};
            dy  = {y[31], y} - {last_y[31], last_y};
            wx  = dx;
            wy  = dy;
            len = root_floor(67'(wx * wx + wy * wy));
            sum = {1'b0, len_acc} + 49'(len);
            len_acc = sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
            if (pts_in_path == 2 && !is_short(last_len) && !is_short(len)
                && corner_is_turn(last_dx, last_dy, dx, dy, last_len, len, cos_thr)
                && turn_acc != {TURN_W{1'b1}})
                turn_acc++;
            last_dx = dx; last_dy = dy; last_len = len;
            pts_in_path = 2;
        end
        last_x = x;
        last_y = y;
        if (last)
        begin
            res.length = len_acc;
            res.turns  = turn_acc;
            expected_paths.push_back(res);
            clear_path_state();
        end
    endtask

    task automatic send_point(input logic [31:0] x, y, input bit last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_point(x, y, last);
        points_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_paths.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_cos(input logic signed [15:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cos_thr = v;
    endtask

    task automatic test_directed();
        send_point(32'h1234_5678, 32'h8765_4321, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b1);
        // right angle, straight run, reversal, repeated point
        send_point(0, 0, 1'b0);
        send_point(10 * UNIT, 0, 1'b0);
        send_point(10 * UNIT, 10 * UNIT, 1'b0);
        send_point(10 * UNIT, 20 * UNIT, 1'b0);
        send_point(10 * UNIT, 5 * UNIT, 1'b0);
        send_point(10 * UNIT, 5 * UNIT, 1'b0);
        send_point(-3 * UNIT, 5 * UNIT, 1'b1);
        send_point(1, 1, 1'b0);
        send_point(2, 2, 1'b0);
        send_point(3, 1, 1'b1);
        drain();
        // threshold exactly met: right angle with cos 0, straight line with cos 1
        write_cos(16'sd0);
        send_point(0, 0, 1'b0);
        send_point(4 * UNIT, 0, 1'b0);
        send_point(4 * UNIT, 3 * UNIT, 1'b1);
        drain();
        write_cos(16'sd16384);
        send_point(0, 0, 1'b0);
        send_point(UNIT, 0, 1'b0);
        send_point(5 * UNIT, 0, 1'b0);
        send_point(5 * UNIT, 1, 1'b1);
        drain();
    endtask

    task automatic random_path(input int n);
        logic [31:0] x, y, sx, sy;
        int          style;
        style = $urandom_range(0, 3);
        x  = $urandom();
        y  = $urandom();
        sx = $urandom_range(0, 1 << 20) - (1 << 19);
        sy = $urandom_range(0, 1 << 20) - (1 << 19);
        for (int i = 0; i < n; i++)
        begin
            send_point(x, y, i == n - 1);
            case (style)
                0:
                begin
                    x = x + $urandom_range(0, 1 << 22) - (1 << 21);
                    y = y + $urandom_range(0, 1 << 22) - (1 << 21);
                end
                1:
                begin
                    x = $urandom();
                    y = $urandom();
                end
                2:
                begin
                    if ($urandom_range(0, 1))
                        x = x + ($urandom_range(0, 4) - 2) * UNIT;
                    else
                        y = y + ($urandom_range(0, 4) - 2) * UNIT;
                end
                default:
                begin
                    x = x + sx + $urandom_range(0, 255) - 128;
                    y = y + sy + $urandom_range(0, 255) - 128;
                end
            endcase
        end
    endtask

    task automatic test_random(input int n_points);
        int start;
        start = points_sent;
        while (points_sent - start < n_points)
            random_path($urandom_range(1, 10));
        drain();
    endtask

    task automatic test_thresholds();
        logic signed [15:0] settings[6] = '{16'sd0, -16'sd16384, 16'sd16384,
                                            16'sd32767, -16'sd32768, 16'sd8192};
        foreach (settings[i])
        begin
            write_cos(settings[i]);
            test_random(40);
        end
        write_cos(16'($urandom_range(0, 32768) - 16384));
        test_random(40);
        write_cos(COS_RESET);
    endtask

    task automatic test_backpressure();
        hold_cycles = 3000;
        for (int i = 0; i < 6; i++)
            random_path($urandom_range(1, 3));
        drain();
        // sender pauses until every result is back
        random_path(4);
        drain();
    endtask

    task automatic test_no_gaps();
        sender_gaps = 1'b0;
        test_random(100);
        sender_gaps = 1'b1;
    endtask

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stretch_left  <= 0;
            ready_mode    <= 0;
        end
        else if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end
        else
        begin
            if (stretch_left == 0)
            begin
                stretch_left <= $urandom_range(20, 400);
                ready_mode   <= $urandom_range(0, 2);
            end
            else
                stretch_left <= stretch_left - 1;
            case (ready_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        path_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_paths.size() == 0)
            begin
                $error("unexpected result transfer %h", m_axis_tdata);
                err_count++;
            end
            else
            begin
                exp_r = expected_paths.pop_front();
                if (m_axis_tdata[47:0] !== exp_r.length)
                begin
                    $error("total_length expected %0d actual %0d",
                           exp_r.length, m_axis_tdata[47:0]);
                    err_count++;
                end
                if (m_axis_tdata[79:48] !== exp_r.turns)
                begin
                    $error("turn_total expected %0d actual %0d",
                           exp_r.turns, m_axis_tdata[79:48]);
                    err_count++;
                end
                paths_checked++;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        err_count     = 0;
        points_sent   = 0;
        paths_checked = 0;
        burst_left    = 0;
        sender_gaps   = 1'b1;
        hold_cycles   = 0;
        cos_thr       = COS_RESET;
        clear_path_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_thresholds();
        test_backpressure();
        test_no_gaps();
        test_random(380);

        drain();
        if (expected_paths.size() != 0)
        begin
            $error("%0d results never arrived", expected_paths.size());
            err_count++;
        end
        $display("Covered %0d points over %0d paths, thresholds from -2 to +2,",
                 points_sent, paths_checked);
        $display("with bursty input, output stalls and one long output hold.");
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

/* filelist.f */
rtl/pltc_pkg.sv
rtl/path_length_and_turn_count_unit.sv
verif/testbench.sv
